>>> rtl/core/aots_pkg.sv
// Shared types and constants for the subtitle override-tag stripper.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package aots_pkg;

    // Open-block replay buffer
    localparam int TAG_BUF_DEPTH = 32;
    localparam int TAG_AW        = $clog2(TAG_BUF_DEPTH);
    localparam int TAG_CW        = $clog2(TAG_BUF_DEPTH + 1);

    // Front-to-back command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_UPPER_N = 8'h4E;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One command from the front: up to two plain bytes, or an end of text
    typedef struct packed {
        logic              is_end;
        logic              rep;
        logic [1:0]        nbytes;
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [TAG_CW-1:0] rep_len;
        logic              trunc;
    } aots_cmd_t;

    // Write port into the replay buffer
    typedef struct packed {
        logic              en;
        logic [TAG_AW-1:0] addr;
        logic [7:0]        data;
    } aots_wr_t;

    // Status from the back end
    typedef struct packed {
        logic replaying;
        logic done;
    } aots_back_status_t;

endpackage

`default_nettype wire

>>> rtl/core/aots_front.sv
// Front end: accepts text words, tracks block/escape/drawing state,
// fills the replay buffer and issues commands. Depends on aots_pkg.
`default_nettype none

module aots_front
    import aots_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_mark,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       q_full,
    input  wire logic       done,
    output logic            push,
    output aots_cmd_t       cmd,
    output aots_wr_t        wr,
    output logic            busy
);

    logic              inside_reg, inside_next;
    logic              draw_reg, draw_next;
    logic              bs_reg, bs_next;
    logic              scan_reg, scan_next;
    logic [TAG_CW-1:0] count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              busy_reg, busy_next;
    logic              accept;

    // Hold off while the queue is full or an end of text is in flight
    assign in_stall = q_full || busy_reg;
    assign accept   = in_valid && !in_stall;
    assign busy     = busy_reg;

    // Classify the word and work out the next state
    always_comb
    begin
        logic handled;
        logic is_digit;
        handled     = 1'b0;
        is_digit    = in_byte inside {[CH_ZERO:CH_NINE]};
        inside_next = inside_reg;
        draw_next   = draw_reg;
        bs_next     = bs_reg;
        scan_next   = scan_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        busy_next   = busy_reg;
        push        = 1'b0;
        cmd         = '0;
        wr          = '0;
        wr.data     = in_byte;
        wr.addr     = count_reg[TAG_AW-1:0];

        if (done)
        begin
            busy_next = 1'b0;
        end

        if (accept)
        begin
            if (end_mark)
            begin
                // End of text: replay an open block, or flush a pending backslash
                push       = 1'b1;
                cmd.is_end = 1'b1;
                if (inside_reg)
                begin
                    cmd.rep     = 1'b1;
                    cmd.rep_len = count_reg;
                    cmd.trunc   = ovf_reg;
                end
                else if (bs_reg && !draw_reg)
                begin
                    cmd.nbytes = 2'd1;
                    cmd.b0     = CH_BSLASH;
                end
                inside_next = 1'b0;
                draw_next   = 1'b0;
                bs_next     = 1'b0;
                scan_next   = 1'b0;
                count_next  = '0;
                ovf_next    = 1'b0;
                busy_next   = 1'b1;
            end
            else if (inside_reg)
            begin
                // Buffer the raw word for a possible replay
                if (count_reg < TAG_CW'(TAG_BUF_DEPTH))
                begin
                    wr.en      = 1'b1;
                    count_next = count_reg + TAG_CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end

                if (scan_reg)
                begin
                    if (is_digit)
                    begin
                        if (in_byte != CH_ZERO)
                        begin
                            draw_next = 1'b1;
                        end
                        handled = 1'b1;
                    end
                    else
                    begin
                        scan_next = 1'b0;
                    end
                end
                if (!handled && bs_reg)
                begin
                    bs_next = 1'b0;
                    if (in_byte == CH_P)
                    begin
                        draw_next = 1'b0;
                        scan_next = 1'b1;
                        handled   = 1'b1;
                    end
                end
                if (!handled)
                begin
                    if (in_byte == CH_RBRACE)
                    begin
                        inside_next = 1'b0;
                        count_next  = '0;
                        ovf_next    = 1'b0;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        bs_next = 1'b1;
                    end
                end
            end
            else
            begin
                // Plain text: resolve a pending escape first
                if (bs_reg)
                begin
                    bs_next = 1'b0;
                    if (in_byte == CH_UPPER_N || in_byte == CH_LOWER_N)
                    begin
                        cmd.nbytes = 2'd1;
                        cmd.b0     = CH_NL;
                        handled    = 1'b1;
                    end
                    else if (in_byte == CH_H)
                    begin
                        cmd.nbytes = 2'd1;
                        cmd.b0     = CH_SPACE;
                        handled    = 1'b1;
                    end
                    else if (!draw_reg)
                    begin
                        cmd.nbytes = 2'd1;
                        cmd.b0     = CH_BSLASH;
                    end
                end
                if (!handled)
                begin
                    if (in_byte == CH_LBRACE)
                    begin
                        inside_next = 1'b1;
                        scan_next   = 1'b0;
                        ovf_next    = 1'b0;
                        wr.en       = 1'b1;
                        wr.addr     = '0;
                        count_next  = TAG_CW'(1);
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        bs_next = 1'b1;
                    end
                    else if (!draw_reg)
                    begin
                        if (cmd.nbytes == 2'd0)
                        begin
                            cmd.b0 = in_byte;
                        end
                        else
                        begin
                            cmd.b1 = in_byte;
                        end
                        cmd.nbytes = cmd.nbytes + 2'd1;
                    end
                end
                push = (cmd.nbytes != 2'd0);
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            draw_reg   <= 1'b0;
            bs_reg     <= 1'b0;
            scan_reg   <= 1'b0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
            draw_reg   <= draw_next;
            bs_reg     <= bs_next;
            scan_reg   <= scan_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aots_queue.sv
// Short command queue between front and back ends.
// Depends on aots_pkg for the command type and depth.
`default_nettype none

module aots_queue
    import aots_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire aots_cmd_t push_cmd,
    input  wire logic      pop,
    output aots_cmd_t      head,
    output logic           empty,
    output logic           full
);

    aots_cmd_t       slots [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign empty   = (cnt_reg == Q_CW'(0));
    assign full    = (cnt_reg == Q_CW'(Q_DEPTH));
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + Q_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - Q_CW'(1);
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aots_back.sv
// Back end: runs queued commands, replays open blocks from the tag buffer
// and drives the registered output words. Depends on aots_pkg.
`default_nettype none

module aots_back
    import aots_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire aots_wr_t   wr,
    input  wire aots_cmd_t  head,
    input  wire logic       q_empty,
    output logic            pop,
    output aots_back_status_t status,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            last_of_run,
    output logic            end_of_text,
    output logic            truncated,
    output logic            out_valid,
    input  wire logic       out_stall
);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_RPL    = 2'd2;
    localparam logic [1:0] PH_TERM   = 2'd3;

    logic [7:0]        tag_mem [TAG_BUF_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [1:0]        phase_reg, phase_next;
    logic [TAG_AW-1:0] idx_reg, idx_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              has_reg, last_reg, eot_reg, trunc_reg;
    logic              out_load;
    logic              emit;
    logic [7:0]        e_byte;
    logic              e_has, e_last, e_eot, e_trunc;

    assign out_load = !out_valid_reg || !out_stall;

    // Step through the head command, at most one output word per cycle, none while a stalled word is held
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        e_byte     = '0;
        e_has      = 1'b0;
        e_last     = 1'b0;
        e_eot      = 1'b0;
        e_trunc    = 1'b0;
        status     = '0;
        status.replaying = (phase_reg == PH_RPL);

        case (phase_reg)
            PH_FIRST:
            begin
                if (!q_empty)
                begin
                    if (head.nbytes != 2'd0)
                    begin
                        if (out_load)
                        begin
                            emit   = 1'b1;
                            e_byte = head.b0;
                            e_has  = 1'b1;
                            e_last = !head.is_end && (head.nbytes == 2'd1);
                            if (head.nbytes == 2'd2)
                            begin
                                phase_next = PH_SECOND;
                            end
                            else if (head.is_end)
                            begin
                                phase_next = PH_TERM;
                            end
                            else
                            begin
                                pop = 1'b1;
                            end
                        end
                    end
                    else if (head.rep && head.rep_len != TAG_CW'(0))
                    begin
                        // Start the replay; first buffer word arrives next cycle
                        phase_next = PH_RPL;
                        idx_next   = '0;
                    end
                    else if (out_load)
                    begin
                        emit        = 1'b1;
                        e_last      = 1'b1;
                        e_eot       = 1'b1;
                        e_trunc     = head.trunc;
                        pop         = 1'b1;
                        status.done = 1'b1;
                    end
                end
            end
            PH_SECOND:
            begin
                if (out_load)
                begin
                    emit       = 1'b1;
                    e_byte     = head.b1;
                    e_has      = 1'b1;
                    e_last     = 1'b1;
                    pop        = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            PH_RPL:
            begin
                if (out_load)
                begin
                    emit   = 1'b1;
                    e_byte = rd_data_reg;
                    e_has  = 1'b1;
                    if (TAG_CW'(idx_reg) + TAG_CW'(1) == head.rep_len)
                    begin
                        phase_next = PH_TERM;
                    end
                    else
                    begin
                        idx_next = idx_reg + TAG_AW'(1);
                    end
                end
            end
            PH_TERM:
            begin
                if (out_load)
                begin
                    emit        = 1'b1;
                    e_last      = 1'b1;
                    e_eot       = 1'b1;
                    e_trunc     = head.trunc;
                    pop         = 1'b1;
                    status.done = 1'b1;
                    phase_next  = PH_FIRST;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    // Tag buffer: write from the front, registered read at the next index
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= tag_mem[idx_next];
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= e_byte;
            has_reg      <= e_has;
            last_reg     <= e_last;
            eot_reg      <= e_eot;
            trunc_reg    <= e_trunc;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign has_byte    = has_reg;
    assign last_of_run = last_reg;
    assign end_of_text = eot_reg;
    assign truncated   = trunc_reg;

endmodule

`default_nettype wire

>>> rtl/core/ass_override_tag_stripper_unit.sv
// Top level of the subtitle override-tag stripper: front end, command
// queue and back end. Depends on aots_pkg, aots_front, aots_queue, aots_back.
//
// Text words enter one per cycle on in_valid/in_stall; an item with
// end_mark closes the string. Words that yield zero or one output word
// flow at one per cycle while out_stall is low; a word that yields two
// output words (a released escape backslash plus the byte) holds the back
// end for both, and the four-entry command queue between the ends absorbs
// such bursts. The end item blocks the input until its terminator is
// loaded into the output register: that is the queue drain, a flushed
// backslash or, for a replayed open block, the start of the tag-buffer
// read and the replayed bytes (up to 32), and the terminator. Output words
// are registered, so out_stall never reaches the input directly. The
// front-end state returns to reset after every end item.
`default_nettype none

module ass_override_tag_stripper_unit
    import aots_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_mark,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            last_of_run,
    output logic            end_of_text,
    output logic            truncated,
    output logic            out_valid,
    input  wire logic       out_stall
);

    aots_cmd_t         push_cmd;
    aots_cmd_t         head;
    aots_wr_t          wr;
    aots_back_status_t status;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              busy;

    aots_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte),
        .end_mark (end_mark),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .done     (status.done),
        .push     (push),
        .cmd      (push_cmd),
        .wr       (wr),
        .busy     (busy)
    );

    aots_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    aots_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .status      (status),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text),
        .truncated   (truncated),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    // Hold a stalled output word unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({out_byte, has_byte, last_of_run, end_of_text, truncated}))
        else $error("output word changed while stalled");

    // Stall the input while an end item is in flight
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("input open while an end item is in flight");

    // Replay only runs for an accepted end item
    a_replay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.replaying |-> busy)
        else $error("replay without an end item in flight");

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for ass_override_tag_stripper_unit: a directed table, then random
// subtitle strings, with every output word scored against an in-bench predictor.
// Depends on aots_pkg and the RTL under rtl/core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aots_pkg::*;

    localparam int IDLE_PCT    = 22;
    localparam int RANDOM_WORDS = 215;
    localparam int MAX_PRINTED = 40;

    // One output word as the block presents it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_text;
        logic       truncated;
    } text_word_t;

    // One directed row; typed rows carry the single word they must produce
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_mark;
        logic       typed;
        logic [7:0] want_byte;
        logic       want_has;
        logic       want_eot;
    } seed_row_t;

    localparam int N_SEED = 29;
    localparam seed_row_t SEED_ROWS [N_SEED] = '{
        // plain bytes right after reset, including both extremes
        '{8'h41,      1'b0, 1'b1, 8'h41,    1'b1, 1'b0},
        '{8'h00,      1'b0, 1'b1, 8'h00,    1'b1, 1'b0},
        '{8'hFF,      1'b0, 1'b1, 8'hFF,    1'b1, 1'b0},
        // newline escapes, upper and lower case
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_UPPER_N, 1'b0, 1'b1, CH_NL,    1'b1, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_LOWER_N, 1'b0, 1'b1, CH_NL,    1'b1, 1'b0},
        // a backslash followed by a backslash, then by an escape letter
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_UPPER_N, 1'b0, 1'b1, CH_NL,    1'b1, 1'b0},
        // backslash before a brace: backslash out, block opens
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_LBRACE,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        // nested brace is ignored, escaped closing brace still closes
        '{CH_LBRACE,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_RBRACE,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        // drawing mode on through a nonzero digit
        '{CH_LBRACE,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_P,       1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_ZERO,    1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{8'h33,      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_RBRACE,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        // text suppressed, escapes still emitted in drawing mode
        '{8'h71,      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{CH_H,       1'b0, 1'b1, CH_SPACE, 1'b1, 1'b0},
        // open block at the end is replayed raw
        '{CH_LBRACE,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{8'h00,      1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
        // pending backslash at the end, then a bare terminator
        '{CH_BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{8'h00,      1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
        '{8'hFF,      1'b1, 1'b1, 8'h00,    1'b0, 1'b1}
    };

    logic       clk;
    logic       rst_n     = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       end_mark  = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       end_of_text;
    logic       truncated;
    logic       out_valid;

    // Predictor state
    logic       blk_open;
    logic       draw_on;
    logic       esc_wait;
    logic       digit_scan;
    logic       blk_over;
    logic [7:0] blk_bytes [TAG_BUF_DEPTH];
    int         blk_count;

    text_word_t item_words [$];
    text_word_t pending_words [$];
    int         mismatches = 0;
    int         items_sent = 0;
    logic       calm = 1'b0;

    ass_override_tag_stripper_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .end_mark    (end_mark),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text),
        .truncated   (truncated),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Return the stripper state to its post-reset values
    function automatic void clear_text();
        blk_open   = 1'b0;
        draw_on    = 1'b0;
        esc_wait   = 1'b0;
        digit_scan = 1'b0;
        blk_over   = 1'b0;
        blk_count  = 0;
    endfunction

    function automatic void put_word(input logic [7:0] b, input logic has, input logic eot,
                                     input logic trunc);
        text_word_t w;
        w.out_byte    = has ? b : 8'h00;
        w.has_byte    = has;
        w.last_of_run = 1'b0;
        w.end_of_text = eot;
        w.truncated   = trunc;
        item_words = {item_words, w};
    endfunction

    // Buffer a block byte for replay; flag anything past the buffer depth
    function automatic void keep_block_byte(input logic [7:0] b);
        if (blk_count < TAG_BUF_DEPTH)
        begin
            blk_bytes[blk_count] = b;
            blk_count++;
        end
        else
            blk_over = 1'b1;
    endfunction

    // Work out the words one accepted input word causes, into item_words
    function automatic void strip_predict(input logic [7:0] b, input logic e);
        logic done;
        logic trunc;
        item_words.delete();
        done = 1'b0;
        if (e)
        begin
            trunc = 1'b0;
            if (blk_open)
            begin
                for (int i = 0; i < blk_count; i++)
                    put_word(blk_bytes[i], 1'b1, 1'b0, 1'b0);
                trunc = blk_over;
            end
            else if (esc_wait && !draw_on)
                put_word(CH_BSLASH, 1'b1, 1'b0, 1'b0);
            put_word(8'h00, 1'b0, 1'b1, trunc);
            clear_text();
        end
        else if (blk_open)
        begin
            keep_block_byte(b);
            // digits after \p decide drawing mode
            if (digit_scan)
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (b != CH_ZERO)
                        draw_on = 1'b1;
                    done = 1'b1;
                end
                else
                    digit_scan = 1'b0;
            end
            if (!done && esc_wait)
            begin
                esc_wait = 1'b0;
                if (b == CH_P)
                begin
                    draw_on    = 1'b0;
                    digit_scan = 1'b1;
                    done       = 1'b1;
                end
            end
            if (!done)
            begin
                if (b == CH_RBRACE)
                begin
                    blk_open  = 1'b0;
                    blk_count = 0;
                    blk_over  = 1'b0;
                end
                else if (b == CH_BSLASH)
                    esc_wait = 1'b1;
            end
        end
        else
        begin
            // resolve a pending backslash first
            if (esc_wait)
            begin
                esc_wait = 1'b0;
                if (b == CH_UPPER_N || b == CH_LOWER_N)
                begin
                    put_word(CH_NL, 1'b1, 1'b0, 1'b0);
                    done = 1'b1;
                end
                else if (b == CH_H)
                begin
                    put_word(CH_SPACE, 1'b1, 1'b0, 1'b0);
                    done = 1'b1;
                end
                else if (!draw_on)
                    put_word(CH_BSLASH, 1'b1, 1'b0, 1'b0);
            end
            if (!done)
            begin
                if (b == CH_LBRACE)
                begin
                    blk_open   = 1'b1;
                    digit_scan = 1'b0;
                    blk_count  = 0;
                    blk_over   = 1'b0;
                    keep_block_byte(b);
                end
                else if (b == CH_BSLASH)
                    esc_wait = 1'b1;
                else if (!draw_on)
                    put_word(b, 1'b1, 1'b0, 1'b0);
            end
        end
        if (item_words.size() > 0)
            item_words[item_words.size() - 1].last_of_run = 1'b1;
    endfunction

    // Offer one input word, hold it until accepted, then record what it causes
    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_byte  <= b;
        end_mark <= e;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        strip_predict(b, e);
        foreach (item_words[i])
            pending_words = {pending_words, item_words[i]};
        items_sent++;
    endtask

    // Build one random subtitle string out of fragments and close it
    task automatic random_text(input int tail);
        int         frags;
        int         kind;
        int         n;
        int         ndig;
        logic [7:0] b;
        frags = $urandom_range(0, 6);
        for (int k = 0; k < frags; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                // run of plain bytes
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (kind < 45)
            begin
                // escape pair
                send_word(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 5))
                    0:       b = CH_UPPER_N;
                    1:       b = CH_LOWER_N;
                    2:       b = CH_H;
                    3:       b = CH_LBRACE;
                    4:       b = CH_BSLASH;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_word(b, 1'b0);
            end
            else if (kind < 85)
            begin
                // closed override block, now and then longer than the buffer
                send_word(CH_LBRACE, 1'b0);
                n = (kind < 48) ? $urandom_range(30, 40) : $urandom_range(0, 4);
                for (int j = 0; j < n; j++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2:
                        begin
                            send_word(CH_BSLASH, 1'b0);
                            send_word(CH_P, 1'b0);
                            ndig = $urandom_range(0, 3);
                            for (int d = 0; d < ndig; d++)
                            begin
                                if ($urandom_range(0, 1) == 0)
                                    send_word(CH_ZERO, 1'b0);
                                else
                                    send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                            end
                        end
                        3:
                            send_word(CH_LBRACE, 1'b0);
                        4:
                        begin
                            send_word(CH_BSLASH, 1'b0);
                            send_word(8'($urandom_range(0, 255)), 1'b0);
                        end
                        default:
                        begin
                            b = 8'($urandom_range(0, 255));
                            send_word((b == CH_RBRACE) ? 8'h41 : b, 1'b0);
                        end
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    send_word(CH_BSLASH, 1'b0);
                send_word(CH_RBRACE, 1'b0);
            end
            else
            begin
                // lone special character, out of any sequence
                case ($urandom_range(0, 5))
                    0:       b = CH_RBRACE;
                    1:       b = CH_LBRACE;
                    2:       b = CH_P;
                    3:       b = CH_ZERO + 8'($urandom_range(0, 9));
                    4:       b = CH_BSLASH;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_word(b, 1'b0);
            end
        end
        // pick an open-block tail unless one was asked for
        if (tail < 0)
        begin
            if ($urandom_range(0, 99) < 5)
                tail = $urandom_range(25, 50);
            else if ($urandom_range(0, 99) < 25)
                tail = $urandom_range(0, 6);
        end
        if (tail >= 0)
        begin
            send_word(CH_LBRACE, 1'b0);
            for (int j = 0; j < tail; j++)
            begin
                b = 8'($urandom_range(0, 255));
                send_word((b == CH_RBRACE) ? CH_LBRACE : b, 1'b0);
            end
        end
        else if ($urandom_range(0, 9) == 0)
            send_word(CH_BSLASH, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stall the output side at random, except in the calm stretch
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Score every accepted output word against the oldest expectation
    always @(posedge clk)
    begin
        text_word_t got;
        text_word_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{out_byte, has_byte, last_of_run, end_of_text, truncated};
            if (pending_words.size() == 0)
                report_mismatch($sformatf(
                    "unexpected word byte %02h has %0b last %0b eot %0b trunc %0b",
                    got.out_byte, got.has_byte, got.last_of_run,
                    got.end_of_text, got.truncated));
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        {"byte %02h/%02h has %0b/%0b last %0b/%0b ",
                         "eot %0b/%0b trunc %0b/%0b (got/exp)"},
                        got.out_byte, want.out_byte, got.has_byte, want.has_byte,
                        got.last_of_run, want.last_of_run, got.end_of_text, want.end_of_text,
                        got.truncated, want.truncated));
            end
        end
    end

    // Stimulus: reset, directed table, random strings, drain
    initial
    begin
        text_word_t want;
        int         t;
        int         tail;
        clear_text();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table; typed rows also vouch for the predictor
        for (int r = 0; r < N_SEED; r++)
        begin
            send_word(SEED_ROWS[r].in_byte, SEED_ROWS[r].end_mark);
            if (SEED_ROWS[r].typed)
            begin
                want = '{SEED_ROWS[r].want_byte, SEED_ROWS[r].want_has, 1'b1,
                         SEED_ROWS[r].want_eot, 1'b0};
                if (item_words.size() != 1 || item_words[0] != want)
                    report_mismatch($sformatf(
                        "directed row %0d disagrees with its typed word", r));
            end
        end

        // random strings; the first three hit the replay buffer edges
        t = 0;
        while (items_sent < N_SEED + RANDOM_WORDS)
        begin
            calm = (t >= 6 && t < 14);
            case (t)
                0:       tail = TAG_BUF_DEPTH - 1;
                1:       tail = TAG_BUF_DEPTH;
                2:       tail = TAG_BUF_DEPTH + 13;
                default: tail = -1;
            endcase
            random_text(tail);
            t++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
